// File: rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5 package
// shared transaction types and constants for the md5 digest core
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // command from front to back: one byte to place, or the end of a message to pad and finish
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_EMIT  = 2'd1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      unique case (r)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
        6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
        6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
        6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    begin
      unique case ({r[5:4], r[1:0]})
        4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
        4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
        4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
        4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; 4'hf: s = 5'd21;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

endpackage

// File: rtl/md5_message_digest_core.sv
// ----------------------------------------------------------------------------
// md5 message digest core
// one byte per transaction in, four digest words out per message
// ----------------------------------------------------------------------------
// a full block is compressed in 64 rounds and an add step; bytes wait meanwhile
// one shared round unit; bytes are taken only in the idle state with no digest word held
// finish pads one byte a cycle and compresses, twice if the length spills over, then emits four words
// reset: synchronous active low, restores initial chaining words, empties queues
module md5_message_digest_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  md5_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output md5_pkg::out_item_t out_item
);

  logic          f_push, f_full, b_empty, b_pop;
  md5_pkg::cmd_t f_item, b_item;

  md5_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .cmd_push(f_push), .cmd_full(f_full), .cmd_item(f_item)
  );

  md5_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_push), .full(f_full), .wr_item(f_item),
    .pop(b_pop), .empty(b_empty), .rd_item(b_item)
  );

  md5_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_empty(b_empty), .cmd_pop(b_pop),
    .cmd_item(b_item), .out_empty(out_empty), .out_pop(out_pop),
    .out_item(out_item)
  );

endmodule

// File: rtl/md5_front.sv
// ----------------------------------------------------------------------------
// md5 front end
// classifies input transactions into byte and finish commands
// ----------------------------------------------------------------------------
module md5_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  md5_pkg::in_item_t  in_item,
  output logic               cmd_push,
  input  logic               cmd_full,
  output md5_pkg::cmd_t      cmd_item
);

  logic       pend_r, pend_nxt;

  // a transaction with a byte and end of message gives two commands
  assign in_full = pend_r | cmd_full;

  always_comb begin
    cmd_push = 1'b0;
    cmd_item.op = md5_pkg::CMD_BYTE;
    cmd_item.data = in_item.data_byte;
    pend_nxt = pend_r;
    if (pend_r) begin
      cmd_push = 1'b1;
      cmd_item.op = md5_pkg::CMD_EMIT;
      if (!cmd_full) begin
        pend_nxt = 1'b0;
      end
    end else if (in_push && !cmd_full) begin
      if (in_item.byte_valid) begin
        cmd_push = 1'b1;
        pend_nxt = in_item.end_of_message;
      end else if (in_item.end_of_message) begin
        cmd_push = 1'b1;
        cmd_item.op = md5_pkg::CMD_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

endmodule

// File: rtl/md5_cmd_fifo.sv
// ----------------------------------------------------------------------------
// md5 command queue
// short queue decoupling front end and compression engine
// ----------------------------------------------------------------------------
module md5_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  md5_pkg::cmd_t  wr_item,
  input  logic           pop,
  output logic           empty,
  output md5_pkg::cmd_t  rd_item
);

  md5_pkg::cmd_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + 2'd1;
      end
      if (pop && !empty) begin
        rp_r <= rp_r + 2'd1;
      end
      cnt_r <= cnt_r + {2'b0, push && !full} - {2'b0, pop && !empty};
    end
    if (push && !full) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

// File: rtl/md5_back.sv
// ----------------------------------------------------------------------------
// md5 back end
// packs bytes, pads, runs the 64 rounds and delivers the digest words
// ----------------------------------------------------------------------------
module md5_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  md5_pkg::cmd_t      cmd_item,
  output logic               out_empty,
  input  logic               out_pop,
  output md5_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  state_t      state_r;
  logic [31:0] blk_r [16];
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [63:0] cnt_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [1:0]  emit_r;
  logic        ovld_r;
  logic [31:0] oword_r;
  logic        olast_r;

  // padding byte generator
  logic [5:0]  pos;
  logic [7:0]  pad_byte;
  logic        pad_first_r;
  logic        len_blk_r;
  assign pos = cnt_r[5:0];

  // the length goes only into the block that carries it
  always_comb begin
    if (pad_first_r) begin
      pad_byte = 8'h80;
    end else if (len_blk_r && pos >= 6'd56) begin
      pad_byte = bits_r[{pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // round datapath
  logic [31:0] f, t, rot, w;
  logic [3:0]  wi;
  logic [4:0]  s;
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        wi = rnd_r[3:0];
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        wi = 4'(({rnd_r[3:0], 2'b00}) + rnd_r[3:0] + 4'd1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        wi = 4'(({rnd_r[3:0], 1'b0}) + rnd_r[3:0] + 4'd5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        wi = 4'(({rnd_r[3:0], 3'b000}) - rnd_r[3:0]);
      end
    endcase
    w = blk_r[wi];
    s = md5_pkg::round_s(rnd_r);
    t = a_r + f + md5_pkg::round_k(rnd_r) + w;
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
  end

  logic take_byte;
  logic [7:0] byte_v;
  always_comb begin
    take_byte = 1'b0;
    byte_v = cmd_item.data;
    cmd_pop = 1'b0;
    if (state_r == ST_IDLE && !cmd_empty && !ovld_r) begin
      cmd_pop = 1'b1;
      take_byte = (cmd_item.op == md5_pkg::CMD_BYTE);
    end else if (state_r == ST_PAD) begin
      take_byte = 1'b1;
      byte_v = pad_byte;
    end
  end

  assign out_empty = !ovld_r;
  assign out_item.digest_word = oword_r;
  assign out_item.digest_last = olast_r;

  always_ff @(posedge clk) begin
    if (take_byte) begin
      if (pos[1:0] == 2'd0) begin
        blk_r[pos[5:2]] <= {24'h0, byte_v};
      end else begin
        blk_r[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= byte_v;
      end
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h_r[0] <= md5_pkg::IV_A;
      h_r[1] <= md5_pkg::IV_B;
      h_r[2] <= md5_pkg::IV_C;
      h_r[3] <= md5_pkg::IV_D;
      cnt_r <= '0;
      rnd_r <= '0;
      fin_r <= 1'b0;
      emit_r <= '0;
      ovld_r <= 1'b0;
      pad_first_r <= 1'b0;
      len_blk_r <= 1'b0;
    end else begin
      if (ovld_r && out_pop && state_r != ST_EMIT) begin
        ovld_r <= 1'b0;
      end
      if (take_byte) begin
        cnt_r <= cnt_r + 64'd1;
        pad_first_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            if (cmd_item.op == md5_pkg::CMD_BYTE) begin
              fin_r <= 1'b0;
              if (pos == 6'd63) begin
                state_r <= ST_ROUND;
              end
            end else begin
              fin_r <= 1'b1;
              bits_r <= {cnt_r[60:0], 3'b000};
              pad_first_r <= 1'b1;
              len_blk_r <= (pos < 6'd56);
              state_r <= ST_PAD;
            end
            a_r <= h_r[0];
            b_r <= h_r[1];
            c_r <= h_r[2];
            d_r <= h_r[3];
            rnd_r <= '0;
          end
        end
        ST_PAD: begin
          a_r <= h_r[0];
          b_r <= h_r[1];
          c_r <= h_r[2];
          d_r <= h_r[3];
          rnd_r <= '0;
          if (pos == 6'd63) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          a_r <= d_r;
          d_r <= c_r;
          c_r <= b_r;
          b_r <= b_r + rot;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          emit_r <= '0;
          if (!fin_r) begin
            state_r <= ST_IDLE;
          end else if (len_blk_r) begin
            state_r <= ST_EMIT;
          end else begin
            len_blk_r <= 1'b1;
            state_r <= ST_PAD;
          end
        end
        ST_EMIT: begin
          if (!ovld_r || out_pop) begin
            ovld_r <= 1'b1;
            oword_r <= h_r[emit_r];
            olast_r <= (emit_r == 2'd3);
            emit_r <= emit_r + 2'd1;
            if (emit_r == 2'd3) begin
              h_r[0] <= md5_pkg::IV_A;
              h_r[1] <= md5_pkg::IV_B;
              h_r[2] <= md5_pkg::IV_C;
              h_r[3] <= md5_pkg::IV_D;
              cnt_r <= '0;
              fin_r <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/md5_checker.sv
// ----------------------------------------------------------------------------
// md5 port checker
// checks result channel behaviour seen at the top level ports
// ----------------------------------------------------------------------------
module md5_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input md5_pkg::out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  a_last_follow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && out_item.digest_last |=> out_empty || !out_item.digest_last)
    else $error("two last words in a row");

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_item(out_item)
);
